/* sv/kld_pkg.sv */
// ----------------------------------------------------------------------------
// kld_pkg: shared types and constants of the keyed-list varint delta decoder
// Record kinds, record and push structs, count limits and the varint
// byte-placement helper.
// ----------------------------------------------------------------------------
package kld_pkg;

  localparam int COUNT_BITS       = 32;
  localparam int MAX_VARINT_BYTES = 10;
  localparam int VCNT_BITS        = 4;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS    = $clog2(FIFO_DEPTH + 1);

  localparam logic [63:0] COUNT_MASK = ((64'd1 << (COUNT_BITS - 1)) << 1) - 64'd1;
  localparam logic [7:0]  VERSION_1  = 8'h01;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h7F;
  localparam logic [7:0]  CONT_MASK    = 8'h80;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_BAD_VER  = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_OVERLONG = 3'd5
  } kind_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    kind_t       kind;
    logic        list_end;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic logic [63:0] place_bits(input logic [6:0] bits,
                                             input logic [VCNT_BITS-1:0] idx);
    logic [63:0] w;
    logic [63:0] r;
    w = {57'd0, bits};
    case (idx)
      4'd0:    r = w;
      4'd1:    r = w << 7;
      4'd2:    r = w << 14;
      4'd3:    r = w << 21;
      4'd4:    r = w << 28;
      4'd5:    r = w << 35;
      4'd6:    r = w << 42;
      4'd7:    r = w << 49;
      4'd8:    r = w << 56;
      4'd9:    r = w << 63;
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic rec_t make_rec(input logic [63:0] key, input logic [63:0] value,
                                    input kind_t kind, input logic list_end);
    rec_t r;
    r.key      = key;
    r.value    = value;
    r.kind     = kind;
    r.list_end = list_end;
    return r;
  endfunction

endpackage

/* sv/kld_step.sv */
// ----------------------------------------------------------------------------
// kld_step: input register and byte-at-a-time parse step
// Registers one byte, then decodes it against the parse state and pushes up
// to two records into the record queue.
// ----------------------------------------------------------------------------
module kld_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             fifo_room,
  output kld_pkg::push_t   push
);
  import kld_pkg::*;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COUNT   = 3'd1,
    PH_KEY     = 3'd2,
    PH_LEN     = 3'd3,
    PH_FIRST   = 3'd4,
    PH_DELTA   = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  logic                  full_r, full_nxt;
  logic [7:0]            byte_r;
  logic                  last_r;
  phase_t                phase_r, phase_nxt;
  logic [63:0]           accum_r, accum_nxt;
  logic [VCNT_BITS-1:0]  vcnt_r, vcnt_nxt;
  logic [COUNT_BITS-1:0] keys_r, keys_nxt;
  logic [COUNT_BITS-1:0] vals_r, vals_nxt;
  logic [63:0]           rkey_r, rkey_nxt;
  logic [63:0]           rval_r, rval_nxt;

  logic                  accept;
  logic                  advance;
  logic [63:0]           z;
  logic [63:0]           v;
  logic                  bad;
  logic [COUNT_BITS-1:0] keys_dec;
  logic [COUNT_BITS-1:0] vals_dec;
  logic [63:0]           val_new;
  logic [1:0]            n;
  rec_t                  r0, r1;

  assign advance  = full_r && fifo_room;
  assign in_stall = full_r && !fifo_room;
  assign accept   = in_valid && !in_stall;
  assign full_nxt = accept ? 1'b1 : (advance ? 1'b0 : full_r);

  assign z        = accum_r | place_bits(byte_r[6:0] & PAYLOAD_MASK[6:0], vcnt_r);
  assign v        = (z >> 1) ^ (64'd0 - {63'd0, z[0]});
  assign bad      = v[63] || ((v & ~COUNT_MASK) != 64'd0);
  assign keys_dec = keys_r - COUNT_BITS'(1);
  assign vals_dec = vals_r - COUNT_BITS'(1);
  assign val_new  = (phase_r == PH_FIRST) ? v : (rval_r + v);

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    vcnt_nxt  = vcnt_r;
    keys_nxt  = keys_r;
    vals_nxt  = vals_r;
    rkey_nxt  = rkey_r;
    rval_nxt  = rval_r;
    n         = 2'd0;
    r0        = make_rec(64'd0, 64'd0, KIND_DONE, 1'b0);
    r1        = make_rec(64'd0, 64'd0, KIND_DONE, 1'b0);

    if (phase_r == PH_VERSION) begin
      if (byte_r != VERSION_1) begin
        r0        = make_rec(64'd0, 64'd0, KIND_BAD_VER, 1'b0);
        n         = 2'd1;
        phase_nxt = PH_ERROR;
      end else begin
        phase_nxt = PH_COUNT;
      end
    end else if (phase_r != PH_DONE && phase_r != PH_ERROR) begin
      accum_nxt = z;
      vcnt_nxt  = vcnt_r + VCNT_BITS'(1);
      if ((byte_r & CONT_MASK) != 8'd0) begin
        if (({1'b0, vcnt_r} + 5'd1) >= 5'(MAX_VARINT_BYTES)) begin
          r0        = make_rec(64'd0, 64'd0, KIND_OVERLONG, 1'b0);
          n         = 2'd1;
          phase_nxt = PH_ERROR;
        end
      end else begin
        accum_nxt = 64'd0;
        vcnt_nxt  = '0;
        case (phase_r)
          PH_COUNT: begin
            if (bad) begin
              r0        = make_rec(64'd0, 64'd0, KIND_OVERLONG, 1'b0);
              n         = 2'd1;
              phase_nxt = PH_ERROR;
            end else if (v == 64'd0) begin
              r0        = make_rec(64'd0, 64'd0, KIND_DONE, 1'b0);
              n         = 2'd1;
              phase_nxt = PH_DONE;
            end else begin
              keys_nxt  = v[COUNT_BITS-1:0];
              phase_nxt = PH_KEY;
            end
          end
          PH_KEY: begin
            rkey_nxt  = rkey_r + v;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (bad) begin
              r0        = make_rec(64'd0, 64'd0, KIND_OVERLONG, 1'b0);
              n         = 2'd1;
              phase_nxt = PH_ERROR;
            end else if (v == 64'd0) begin
              r0       = make_rec(rkey_r, 64'd0, KIND_EMPTY, 1'b0);
              n        = 2'd1;
              keys_nxt = keys_dec;
              if (keys_dec == '0) begin
                r1        = make_rec(64'd0, 64'd0, KIND_DONE, 1'b0);
                n         = 2'd2;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_KEY;
              end
            end else begin
              vals_nxt  = v[COUNT_BITS-1:0];
              phase_nxt = PH_FIRST;
            end
          end
          PH_FIRST, PH_DELTA: begin
            rval_nxt = val_new;
            vals_nxt = vals_dec;
            r0       = make_rec(rkey_r, val_new, KIND_VALUE, vals_dec == '0);
            n        = 2'd1;
            if (vals_dec == '0) begin
              keys_nxt = keys_dec;
              if (keys_dec == '0) begin
                r1        = make_rec(64'd0, 64'd0, KIND_DONE, 1'b0);
                n         = 2'd2;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_KEY;
              end
            end else begin
              phase_nxt = PH_DELTA;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    if (last_r) begin
      if (phase_nxt != PH_ERROR && phase_nxt != PH_DONE) begin
        if (n == 2'd0) begin
          r0 = make_rec(64'd0, 64'd0, KIND_TRUNC, 1'b0);
        end else begin
          r1 = make_rec(64'd0, 64'd0, KIND_TRUNC, 1'b0);
        end
        n = n + 2'd1;
      end
      phase_nxt = PH_VERSION;
      accum_nxt = 64'd0;
      vcnt_nxt  = '0;
      keys_nxt  = '0;
      vals_nxt  = '0;
      rkey_nxt  = 64'd0;
      rval_nxt  = 64'd0;
    end
  end

  always_comb begin
    push.n    = advance ? n : 2'd0;
    push.rec0 = r0;
    push.rec1 = r1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (!rst_n) begin
      full_r  <= 1'b0;
      phase_r <= PH_VERSION;
      accum_r <= 64'd0;
      vcnt_r  <= '0;
      keys_r  <= '0;
      vals_r  <= '0;
      rkey_r  <= 64'd0;
      rval_r  <= 64'd0;
    end else begin
      full_r <= full_nxt;
      if (advance) begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        vcnt_r  <= vcnt_nxt;
        keys_r  <= keys_nxt;
        vals_r  <= vals_nxt;
        rkey_r  <= rkey_nxt;
        rval_r  <= rval_nxt;
      end
    end
  end

endmodule

/* sv/kld_rec_fifo.sv */
// ----------------------------------------------------------------------------
// kld_rec_fifo: record queue
// Takes up to two records per cycle from the parse step and hands out one
// record per output transaction.
// ----------------------------------------------------------------------------
module kld_rec_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  kld_pkg::push_t   push,
  output logic             fifo_room,
  output logic             out_valid,
  input  logic             out_stall,
  output kld_pkg::rec_t    head
);
  import kld_pkg::*;

  rec_t                     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_r, wr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_r, rd_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     pop;
  logic [FIFO_PTR_BITS-1:0] wr_p1;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_r];
  assign fifo_room = cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
  assign wr_p1     = wr_r + FIFO_PTR_BITS'(1);
  assign wr_nxt    = wr_r + FIFO_PTR_BITS'(push.n);
  assign rd_nxt    = pop ? (rd_r + FIFO_PTR_BITS'(1)) : rd_r;
  assign cnt_nxt   = cnt_r + FIFO_CNT_BITS'(push.n) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.rec0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_p1] <= push.rec1;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/keyed_list_varint_delta_decoder_top.sv */
// ----------------------------------------------------------------------------
// keyed_list_varint_delta_decoder_top: zigzag varint delta map decoder
// Path: input register, parse step, record queue; the queue head is the output.
// Throughput: one byte per cycle, set by the single parse step, while the queue
// has room; a byte that yields two records is absorbed by a four-entry queue.
// Reset: synchronous, active low; clears parse state, input register and queue.
// ----------------------------------------------------------------------------
module keyed_list_varint_delta_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_entry_key,
  output logic signed [63:0] out_entry_value,
  output logic [2:0]         out_record_kind,
  output logic               out_list_end
);
  import kld_pkg::*;

  push_t push;
  rec_t  head;
  logic  fifo_room;

  kld_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fifo_room    (fifo_room),
    .push         (push)
  );

  kld_rec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fifo_room (fifo_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_entry_key   = head.key;
  assign out_entry_value = head.value;
  assign out_record_kind = head.kind;
  assign out_list_end    = head.list_end;

endmodule

/* sv/kld_checker.sv */
// ----------------------------------------------------------------------------
// kld_checker: port-level checks of the decoder
// Record field consistency and output hold under stall.
// ----------------------------------------------------------------------------
module kld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] out_entry_key,
  input logic signed [63:0] out_entry_value,
  input logic [2:0]         out_record_kind,
  input logic               out_list_end
);
  import kld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_key) &&
      $stable(out_entry_value) && $stable(out_record_kind) && $stable(out_list_end))
    else $error("output transaction changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_record_kind <= KIND_OVERLONG)
    else $error("undefined record kind");

  a_end_on_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_end |-> out_record_kind == KIND_VALUE)
    else $error("list end on a non-value record");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != KIND_VALUE |-> out_entry_value == 64'sd0)
    else $error("nonzero value on a non-value record");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != KIND_VALUE && out_record_kind != KIND_EMPTY
      |-> out_entry_key == 64'sd0)
    else $error("nonzero key on a status record");

endmodule

bind keyed_list_varint_delta_decoder_top kld_checker u_kld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_entry_key   (out_entry_key),
  .out_entry_value (out_entry_value),
  .out_record_kind (out_record_kind),
  .out_list_end    (out_list_end)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the keyed-list zigzag varint delta decoder
// Streams version-1 map files one byte per transaction: a directed opening,
// then random files, most of them well formed with random keys and values,
// the rest with a bad version, overlong varints, bad counts, truncation or
// noise. A decoder model predicts every record; the monitor compares each
// record field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import kld_pkg::*;

  typedef enum logic [2:0] {
    PH_VERSION, PH_COUNT, PH_KEY, PH_LEN, PH_FIRST, PH_DELTA, PH_DONE, PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } byte_item_t;

  localparam int NUM_ITEMS      = 1400;
  localparam int IDLE_PCT       = 11;
  localparam int QUIET_START    = 700;
  localparam int QUIET_END      = 1100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  // {last, data} of the directed opening
  localparam logic [8:0] DIRECTED [25] = '{
    9'h102,
    9'h001, 9'h100,
    9'h001, 9'h101,
    9'h001, 9'h002, 9'h001, 9'h000, 9'h104,
    9'h001, 9'h002, 9'h000, 9'h102,
    9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h1FF
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_entry_key;
  logic signed [63:0] out_entry_value;
  logic [2:0]         out_record_kind;
  logic               out_list_end;

  byte_item_t  stream_q[$];
  logic [7:0]  file_buf[$];
  rec_t        record_q[$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          idle_cycles = 0;

  phase_t      phase = PH_VERSION;
  logic [63:0] acc = '0;
  int unsigned nbytes = 0;
  logic [63:0] keys_left = '0;
  logic [63:0] vals_left = '0;
  logic [63:0] cur_key = '0;
  logic [63:0] cur_val = '0;

  keyed_list_varint_delta_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_key   (out_entry_key),
    .out_entry_value (out_entry_value),
    .out_record_kind (out_record_kind),
    .out_list_end    (out_list_end)
  );

  always #10 clk = ~clk;

  function automatic void put_byte(logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endfunction

  function automatic void clear_decoder();
    phase     = PH_VERSION;
    acc       = '0;
    nbytes    = 0;
    keys_left = '0;
    vals_left = '0;
    cur_key   = '0;
    cur_val   = '0;
  endfunction

  function automatic void expect_record(logic [63:0] key, logic [63:0] value, kind_t kind,
                                        logic lend);
    rec_t r;
    r.key      = key;
    r.value    = value;
    r.kind     = kind;
    r.list_end = lend;
    record_q.insert(record_q.size(), r);
  endfunction

  function automatic bit count_invalid(logic [63:0] v);
    return v[63] || (v > COUNT_MASK);
  endfunction

  function automatic void close_key();
    keys_left = (keys_left - 64'd1) & COUNT_MASK;
    if (keys_left == '0) begin
      expect_record('0, '0, KIND_DONE, 1'b0);
      phase = PH_DONE;
    end else begin
      phase = PH_KEY;
    end
  endfunction

  function automatic void apply_varint(logic [63:0] v);
    case (phase)
      PH_COUNT: begin
        if (count_invalid(v)) begin
          expect_record('0, '0, KIND_OVERLONG, 1'b0);
          phase = PH_ERROR;
        end else if (v == '0) begin
          expect_record('0, '0, KIND_DONE, 1'b0);
          phase = PH_DONE;
        end else begin
          keys_left = v;
          phase = PH_KEY;
        end
      end
      PH_KEY: begin
        cur_key = cur_key + v;
        phase = PH_LEN;
      end
      PH_LEN: begin
        if (count_invalid(v)) begin
          expect_record('0, '0, KIND_OVERLONG, 1'b0);
          phase = PH_ERROR;
        end else if (v == '0) begin
          expect_record(cur_key, '0, KIND_EMPTY, 1'b0);
          close_key();
        end else begin
          vals_left = v;
          phase = PH_FIRST;
        end
      end
      PH_FIRST, PH_DELTA: begin
        cur_val = (phase == PH_FIRST) ? v : cur_val + v;
        vals_left = (vals_left - 64'd1) & COUNT_MASK;
        expect_record(cur_key, cur_val, KIND_VALUE, vals_left == '0);
        if (vals_left == '0) begin
          close_key();
        end else begin
          phase = PH_DELTA;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [63:0] z;
    if (phase == PH_VERSION) begin
      if (b != VERSION_1) begin
        expect_record('0, '0, KIND_BAD_VER, 1'b0);
        phase = PH_ERROR;
      end else begin
        phase = PH_COUNT;
      end
    end else if (phase != PH_DONE && phase != PH_ERROR) begin
      acc = acc | ({57'd0, b[6:0]} << (7 * nbytes));
      nbytes++;
      if ((b & CONT_MASK) != 8'd0) begin
        if (nbytes >= MAX_VARINT_BYTES) begin
          expect_record('0, '0, KIND_OVERLONG, 1'b0);
          phase = PH_ERROR;
        end
      end else begin
        z = (acc >> 1) ^ {64{acc[0]}};
        acc = '0;
        nbytes = 0;
        apply_varint(z);
      end
    end
    if (last) begin
      if (phase != PH_ERROR && phase != PH_DONE) begin
        expect_record('0, '0, KIND_TRUNC, 1'b0);
      end
      clear_decoder();
    end
  endfunction

  function automatic logic [63:0] zigzag(logic [63:0] v);
    return (v << 1) ^ {64{v[63]}};
  endfunction

  // pad: spread over ten bytes, with junk above bit 63 in the tenth
  function automatic void put_varint(logic [63:0] z, bit pad);
    if (pad) begin
      for (int i = 0; i < 9; i++) begin
        put_byte({1'b1, z[7*i +: 7]});
      end
      put_byte({1'b0, 6'($urandom), z[63]});
    end else begin
      while (z > 64'h7F) begin
        put_byte({1'b1, z[6:0]});
        z = z >> 7;
      end
      put_byte({1'b0, z[6:0]});
    end
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = 64'h8000_0000_0000_0000;
      1: r = 64'h7FFF_FFFF_FFFF_FFFF;
      2: r = '0;
      3: r = '1;
      4, 5, 6: r = r >> $urandom_range(40, 63);
      7: r = ~(r >> $urandom_range(40, 63));
      default: ;
    endcase
    return r;
  endfunction

  function automatic void build_map(bit pad_on);
    int unsigned nkeys;
    int unsigned nvals;
    nkeys = $urandom_range(0, 4);
    put_byte(VERSION_1);
    put_varint(zigzag(64'(nkeys)), pad_on && $urandom_range(0, 3) == 0);
    for (int k = 0; k < nkeys; k++) begin
      nvals = $urandom_range(0, 4);
      put_varint(zigzag(rand_value()), pad_on && $urandom_range(0, 3) == 0);
      put_varint(zigzag(64'(nvals)), pad_on && $urandom_range(0, 3) == 0);
      for (int j = 0; j < nvals; j++) begin
        put_varint(zigzag(rand_value()), pad_on && $urandom_range(0, 3) == 0);
      end
    end
  endfunction

  function automatic void add_noise(int unsigned lo, int unsigned hi);
    repeat ($urandom_range(lo, hi)) put_byte(8'($urandom));
  endfunction

  function automatic void flush_file(bit drain);
    byte_item_t it;
    for (int i = 0; i < file_buf.size(); i++) begin
      it.data  = file_buf[i];
      it.last  = (i == file_buf.size() - 1);
      it.drain = drain && (i == 0);
      stream_q.insert(stream_q.size(), it);
    end
    file_buf.delete();
  endfunction

  initial begin
    byte_item_t  it;
    logic [7:0]  ver;
    int unsigned cut;
    bit          hold;
    bit          drain_used;
    drain_used = 1'b0;
    foreach (DIRECTED[i]) begin
      it.data  = DIRECTED[i][7:0];
      it.last  = DIRECTED[i][8];
      it.drain = 1'b0;
      stream_q.insert(stream_q.size(), it);
    end
    while (stream_q.size() < NUM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          ver = 8'($urandom);
          if (ver == VERSION_1) begin
            ver = 8'h02;
          end
          put_byte(ver);
          add_noise(0, 4);
        end
        1: begin
          put_byte(VERSION_1);
          if ($urandom_range(0, 1) == 1) begin
            put_varint(zigzag(64'd1), 1'b0);
          end
          repeat (10) put_byte(CONT_MASK | 8'($urandom));
          add_noise(0, 3);
        end
        2: begin
          put_byte(VERSION_1);
          put_varint(zigzag(~64'($urandom_range(0, 1000))), 1'b0);
          add_noise(0, 3);
        end
        3: begin
          put_byte(VERSION_1);
          put_varint(zigzag(COUNT_MASK + 64'($urandom_range(1, 50))), 1'b0);
          add_noise(0, 3);
        end
        4: begin
          put_byte(VERSION_1);
          put_varint(zigzag(64'($urandom_range(1, 3))), 1'b0);
          put_varint(zigzag(rand_value()), 1'b0);
          if ($urandom_range(0, 1) == 1) begin
            put_varint(zigzag(~64'($urandom_range(0, 1000))), 1'b0);
          end else begin
            put_varint(zigzag(COUNT_MASK + 64'($urandom_range(1, 50))), 1'b0);
          end
          add_noise(0, 3);
        end
        5, 6: begin
          build_map($urandom_range(0, 4) == 0);
          cut = $urandom_range(1, file_buf.size());
          file_buf = file_buf[0:cut-1];
        end
        7: begin
          add_noise(1, 12);
        end
        8: begin
          put_byte(VERSION_1);
          put_varint(zigzag(COUNT_MASK - 64'($urandom_range(0, 3))), 1'b0);
          put_varint(zigzag(rand_value()), 1'b0);
          put_varint(zigzag(64'd1), 1'b0);
          put_varint(zigzag(rand_value()), 1'b0);
          if ($urandom_range(0, 1) == 1) begin
            put_varint(zigzag(rand_value()), 1'b0);
            put_varint(zigzag(COUNT_MASK), 1'b0);
          end
        end
        default: begin
          build_map($urandom_range(0, 4) == 0);
          if ($urandom_range(0, 4) == 0) begin
            add_noise(1, 4);
          end
        end
      endcase
      hold = !drain_used && stream_q.size() >= NUM_ITEMS / 2;
      drain_used |= hold;
      flush_file(hold);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (stream_q.size() != 0 || in_valid) @(negedge clk);
    while (record_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    byte_item_t nxt;
    bit         quiet;
    bit         pause;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte, in_last_byte);
      end
      if (!in_valid || !in_stall) begin
        quiet = cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END;
        pause = !quiet && $urandom_range(0, 99) < IDLE_PCT;
        if (stream_q.size() != 0 && stream_q[0].drain && record_q.size() != 0) begin
          pause = 1'b1;
        end
        if (stream_q.size() != 0 && !pause) begin
          nxt = stream_q.pop_front();
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    rec_t want;
    bit   quiet;
    quiet = cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END;
    if (rst_n && out_valid && !out_stall) begin
      if (record_q.size() == 0) begin
        errors++;
        $error("unexpected record: kind %0d key %h value %h", out_record_kind,
               out_entry_key, out_entry_value);
      end else begin
        want = record_q.pop_front();
        if (out_entry_key !== want.key) begin
          errors++;
          $error("entry_key mismatch: expected %h, actual %h", want.key, out_entry_key);
        end
        if (out_entry_value !== want.value) begin
          errors++;
          $error("entry_value mismatch: expected %h, actual %h", want.value, out_entry_value);
        end
        if (out_record_kind !== want.kind) begin
          errors++;
          $error("record_kind mismatch: expected %0d, actual %0d", want.kind, out_record_kind);
        end
        if (out_list_end !== want.list_end) begin
          errors++;
          $error("list_end mismatch: expected %0d, actual %0d", want.list_end, out_list_end);
        end
      end
    end
    out_stall <= rst_n && !quiet && $urandom_range(0, 99) < IDLE_PCT;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
sv/kld_pkg.sv
sv/kld_step.sv
sv/kld_rec_fifo.sv
sv/keyed_list_varint_delta_decoder_top.sv
sv/kld_checker.sv
sim/tb_top.sv
